FILE: sv/gcv_pkg.sv
// gcv_pkg: shared widths, fault codes and flag struct for the guiding-centre
// velocity converter. No dependencies.
package gcv_pkg;

	localparam int SHRINK_W = 32;
	localparam int SQ_W     = 64;
	localparam int ROOT_W   = 32;
	localparam int SQ_REM_W = 34;

	localparam logic [63:0] SHRINK_LIMIT = 64'h0000_0000_8000_0000;

	typedef enum logic [1:0] {
		FLT_OK         = 2'd0,
		FLT_ZERO_FIELD = 2'd1,
		FLT_ZERO_DIV   = 2'd2
	} fault_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} unit_flags_t;

endpackage

FILE: sv/gcv_sqrt_cell.sv
// gcv_sqrt_cell: one root bit of a pipelined 64-bit integer square root.
// Depends on gcv_pkg.
module gcv_sqrt_cell
	import gcv_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic [SQ_W-1:0]     rad_i,
	input  logic [SQ_REM_W-1:0] rem_i,
	input  logic [ROOT_W-1:0]   root_i,
	input  logic [SW-1:0]       side_i,
	output logic                vld_o,
	output logic [SQ_W-1:0]     rad_o,
	output logic [SQ_REM_W-1:0] rem_o,
	output logic [ROOT_W-1:0]   root_o,
	output logic [SW-1:0]       side_o
);

	logic [SQ_REM_W+1:0] acc;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	logic                ge;

	assign acc   = {rem_i, rad_i[SQ_W-1 -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign diff  = acc - trial;
	assign ge    = acc >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= {rad_i[SQ_W-3:0], 2'b00};
			rem_o  <= ge ? diff[SQ_REM_W-1:0] : acc[SQ_REM_W-1:0];
			root_o <= {root_i[ROOT_W-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule

FILE: sv/gcv_div_cell.sv
// gcv_div_cell: one quotient bit of a pipelined restoring divider, several
// lanes sharing one divisor. Depends on gcv_pkg.
module gcv_div_cell
	import gcv_pkg::*;
#(
	parameter int LANES = 1,
	parameter int RW    = 8,
	parameter int DW    = 8,
	parameter int QW    = 8,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [RW-1:0]              d_i,
	input  logic [LANES-1:0][RW-1:0]   rem_i,
	input  logic [LANES-1:0][DW-1:0]   dv_i,
	input  logic [LANES-1:0][QW-1:0]   q_i,
	input  logic [SW-1:0]              side_i,
	output logic                       vld_o,
	output logic [RW-1:0]              d_o,
	output logic [LANES-1:0][RW-1:0]   rem_o,
	output logic [LANES-1:0][DW-1:0]   dv_o,
	output logic [LANES-1:0][QW-1:0]   q_o,
	output logic [SW-1:0]              side_o
);

	logic [LANES-1:0][RW:0] acc;
	logic [LANES-1:0][RW:0] diff;
	logic [LANES-1:0]       ge;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			acc[l]  = {rem_i[l], dv_i[l][DW-1]};
			diff[l] = acc[l] - {1'b0, d_i};
			ge[l]   = acc[l] >= {1'b0, d_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o    <= d_i;
			side_o <= side_i;
			for (int l = 0; l < LANES; l++) begin
				rem_o[l] <= ge[l] ? diff[l][RW-1:0] : acc[l][RW-1:0];
				dv_o[l]  <= {dv_i[l][DW-2:0], 1'b0};
				q_o[l]   <= {q_i[l][QW-2:0], ge[l]};
			end
		end
	end

endmodule

FILE: sv/gcv_unit.sv
// gcv_unit: shrink, length and unit vector of a signed 3-vector given as
// magnitudes and signs. Depends on gcv_pkg, gcv_sqrt_cell, gcv_div_cell.
module gcv_unit
	import gcv_pkg::*;
#(
	parameter int FRAC = 16,
	parameter int MW   = 32,
	parameter int SW   = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_i,
	input  logic [2:0][MW-1:0]     mag_i,
	input  logic [2:0]             neg_i,
	input  logic [SW-1:0]          side_i,
	output logic                   vld_o,
	output logic [2:0][FRAC:0]     u_o,
	output unit_flags_t            flags_o,
	output logic [SW-1:0]          side_o
);

	localparam int XW  = (MW > SHRINK_W) ? MW : SHRINK_W;
	localparam int SHW = $clog2(XW);
	localparam int SSW = SW + 3 + 3 * SHRINK_W;
	localparam int DSW = SW + 4;
	localparam int NDC = FRAC + 1;

	logic [2:0][XW-1:0]       ext;
	logic [XW-1:0]            top;
	logic [SHW-1:0]           sh;
	logic [2:0][XW-1:0]       shd;

	logic                     vld_s1, vld_s2, vld_s3;
	logic [2:0][SHRINK_W-1:0] sm_s1, sm_s2, sm_s3;
	logic [2:0]               neg_s1, neg_s2, neg_s3;
	logic [SW-1:0]            side_s1, side_s2, side_s3;
	logic [2:0][SQ_W-1:0]     sq_s2;
	logic [SQ_W-1:0]          sum_s3;

	always_comb begin
		for (int i = 0; i < 3; i++)
			ext[i] = XW'(mag_i[i]);
		top = ext[0];
		if (ext[1] > top)
			top = ext[1];
		if (ext[2] > top)
			top = ext[2];
		sh = '0;
		for (int i = XW - 1; i >= 0; i--) begin
			if ((top >> i) <= SHRINK_LIMIT[XW-1:0])
				sh = SHW'(i);
		end
		for (int i = 0; i < 3; i++)
			shd[i] = ext[i] >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sm_s1[i] <= shd[i][SHRINK_W-1:0];
				sq_s2[i] <= sm_s1[i] * sm_s1[i];
			end
			neg_s1  <= neg_i;
			side_s1 <= side_i;
			sm_s2   <= sm_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sm_s3   <= sm_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	// square root chain
	logic [ROOT_W:0]     sq_vld;
	logic [SQ_W-1:0]     sq_rad  [ROOT_W+1];
	logic [SQ_REM_W-1:0] sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
	logic [SSW-1:0]      sq_side [ROOT_W+1];

	assign sq_vld[0]  = vld_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {side_s3, neg_s3, sm_s3};

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		gcv_sqrt_cell #(.SW(SSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_vld[g]),
			.rad_i  (sq_rad[g]),
			.rem_i  (sq_rem[g]),
			.root_i (sq_root[g]),
			.side_i (sq_side[g]),
			.vld_o  (sq_vld[g+1]),
			.rad_o  (sq_rad[g+1]),
			.rem_o  (sq_rem[g+1]),
			.root_o (sq_root[g+1]),
			.side_o (sq_side[g+1])
		);
	end

	logic [SW-1:0]            side_r;
	logic [2:0]               neg_r;
	logic [2:0][SHRINK_W-1:0] sm_r;
	logic [ROOT_W-1:0]        len_r;

	assign {side_r, neg_r, sm_r} = sq_side[ROOT_W];
	assign len_r = sq_root[ROOT_W];

	// division chain, three lanes over the common length
	logic [NDC:0]               dc_vld;
	logic [ROOT_W-1:0]          dc_d    [NDC+1];
	logic [2:0][ROOT_W-1:0]     dc_rem  [NDC+1];
	logic [2:0][FRAC:0]         dc_dv   [NDC+1];
	logic [2:0][FRAC:0]         dc_q    [NDC+1];
	logic [DSW-1:0]             dc_side [NDC+1];

	assign dc_vld[0]  = sq_vld[ROOT_W];
	assign dc_d[0]    = len_r;
	assign dc_q[0]    = '0;
	assign dc_side[0] = {side_r, neg_r, len_r == '0};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dc_rem[0][i] = {1'b0, sm_r[i][SHRINK_W-1:1]};
			dc_dv[0][i]  = {sm_r[i][0], {FRAC{1'b0}}};
		end
	end

	for (genvar g = 0; g < NDC; g++) begin : g_div
		gcv_div_cell #(
			.LANES (3),
			.RW    (ROOT_W),
			.DW    (FRAC + 1),
			.QW    (FRAC + 1),
			.SW    (DSW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dc_vld[g]),
			.d_i    (dc_d[g]),
			.rem_i  (dc_rem[g]),
			.dv_i   (dc_dv[g]),
			.q_i    (dc_q[g]),
			.side_i (dc_side[g]),
			.vld_o  (dc_vld[g+1]),
			.d_o    (dc_d[g+1]),
			.rem_o  (dc_rem[g+1]),
			.dv_o   (dc_dv[g+1]),
			.q_o    (dc_q[g+1]),
			.side_o (dc_side[g+1])
		);
	end

	assign vld_o = dc_vld[NDC];
	assign u_o   = dc_q[NDC];
	assign {side_o, flags_o.neg, flags_o.zero} = dc_side[NDC];

endmodule

FILE: sv/guiding_center_velocity_to_3d.sv
// guiding_center_velocity_to_3d: turns a parallel and a perpendicular speed
// plus the local field vector (signed Q format, FRAC_BITS fraction bits) into
// a saturated 3D velocity. One word is taken every cycle while the skid
// entry is empty. The pipeline is made of the two square root chains (32
// cells each), the three divider chains (FRAC_BITS+1 and 2*FRAC_BITS+2
// cells) and the multiply stages. A two-entry output buffer keeps input
// flowing while a result waits. m_tuser gives the fault code:
// 0 ok, 1 zero field, 2 zero divisor; velocity reads zero on a fault.
// Depends on gcv_pkg, gcv_unit, gcv_div_cell.
module guiding_center_velocity_to_3d
	import gcv_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// speed_parallel, speed_perpendicular, field_x, field_y, field_z
	input  logic [((5*WORD_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// vel_x, vel_y, vel_z
	output logic [((3*WORD_BITS+7)/8)*8-1:0]      m_tdata,
	// fault
	output logic [1:0]                            m_tuser
);

	localparam int W     = WORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int OUT_W = ((3*WORD_BITS+7)/8)*8;
	localparam int QW2   = 2*F + 2;
	localparam int SW1   = 2*W;
	localparam int SLW   = 2*W + 3*(F+1) + 3 + 5;
	localparam int SW2   = 2*W + 3*(F+1) + 5;

	localparam logic [QW2-1:0] ONE_Q = {{(F+1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [W+3:0] SAT_HI = {{5{1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [W+3:0] SAT_LO = {{5{1'b1}}, {(W-1){1'b0}}};

	logic en;
	logic skid_vld_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	// input unpack and field magnitudes
	logic [W-1:0]      vpar_in, vperp_in;
	logic [2:0][W-1:0] fld, fmag;
	logic [2:0]        fneg;

	assign vpar_in  = s_tdata[W-1:0];
	assign vperp_in = s_tdata[2*W-1:W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fld[i]  = s_tdata[(i+2)*W +: W];
			fneg[i] = fld[i][W-1];
			fmag[i] = fneg[i] ? (~fld[i] + 1'b1) : fld[i];
		end
	end

	logic              u1_vld;
	logic [2:0][F:0]   ub;
	unit_flags_t       fl1;
	logic [SW1-1:0]    side1;

	gcv_unit #(.FRAC(F), .MW(W), .SW(SW1)) u_bhat (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (s_tvalid),
		.mag_i   (fmag),
		.neg_i   (fneg),
		.side_i  ({vpar_in, vperp_in}),
		.vld_o   (u1_vld),
		.u_o     (ub),
		.flags_o (fl1),
		.side_o  (side1)
	);

	// pick the solved component
	logic signed [F+1:0] bhs [3];
	logic [F+1:0]        ubx [3];
	logic [1:0]          k_c;
	logic signed [F+2:0] num_c;
	logic signed [F+1:0] den_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ubx[i] = {1'b0, ub[i]};
			bhs[i] = fl1.neg[i] ? -ubx[i] : ubx[i];
		end
		if (bhs[2] > bhs[1] && bhs[2] > bhs[0]) begin
			k_c   = 2'd2;
			num_c = (F+3)'(bhs[0]) + (F+3)'(bhs[1]);
		end else if (bhs[1] > bhs[0]) begin
			k_c   = 2'd1;
			num_c = (F+3)'(bhs[2]) + (F+3)'(bhs[0]);
		end else begin
			k_c   = 2'd0;
			num_c = (F+3)'(bhs[1]) + (F+3)'(bhs[2]);
		end
		den_c = bhs[k_c];
	end

	logic                vld_s1;
	logic [1:0]          k_s1;
	logic signed [F+2:0] num_s1;
	logic signed [F+1:0] den_s1;
	logic [2:0][F:0]     ub_s1;
	logic [2:0]          nb_s1;
	logic                zero1_s1;
	logic [SW1-1:0]      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= u1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1     <= k_c;
			num_s1   <= num_c;
			den_s1   <= den_c;
			ub_s1    <= ub;
			nb_s1    <= fl1.neg;
			zero1_s1 <= fl1.zero;
			side_s1  <= side1;
		end
	end

	logic [F+2:0] num_abs;
	logic [F+1:0] den_abs;
	logic         negq;
	logic         den0;

	assign num_abs = num_s1[F+2] ? -num_s1 : num_s1;
	assign den_abs = den_s1[F+1] ? -den_s1 : den_s1;
	assign negq    = (num_s1 != '0) && (num_s1[F+2] == den_s1[F+1]);
	assign den0    = den_s1 == '0;

	// solve chain
	logic [QW2:0]          sd_vld;
	logic [F:0]            sd_d    [QW2+1];
	logic [0:0][F:0]       sd_rem  [QW2+1];
	logic [0:0][QW2-1:0]   sd_dv   [QW2+1];
	logic [0:0][QW2-1:0]   sd_q    [QW2+1];
	logic [SLW-1:0]        sd_side [QW2+1];

	assign sd_vld[0]    = vld_s1;
	assign sd_d[0]      = den_abs[F:0];
	assign sd_rem[0]    = '0;
	assign sd_dv[0][0]  = {num_abs[F+1:0], {F{1'b0}}};
	assign sd_q[0]      = '0;
	assign sd_side[0]   = {side_s1, ub_s1, nb_s1, zero1_s1, den0, negq, k_s1};

	for (genvar g = 0; g < QW2; g++) begin : g_solve
		gcv_div_cell #(
			.LANES (1),
			.RW    (F + 1),
			.DW    (QW2),
			.QW    (QW2),
			.SW    (SLW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sd_vld[g]),
			.d_i    (sd_d[g]),
			.rem_i  (sd_rem[g]),
			.dv_i   (sd_dv[g]),
			.q_i    (sd_q[g]),
			.side_i (sd_side[g]),
			.vld_o  (sd_vld[g+1]),
			.d_o    (sd_d[g+1]),
			.rem_o  (sd_rem[g+1]),
			.dv_o   (sd_dv[g+1]),
			.q_o    (sd_q[g+1]),
			.side_o (sd_side[g+1])
		);
	end

	logic [SW1-1:0]    side_c;
	logic [2:0][F:0]   ub_c;
	logic [2:0]        nb_c;
	logic              zero1_c, den0_c, negq_c;
	logic [1:0]        ks_c;
	logic [2:0][QW2-1:0] pmag;
	logic [2:0]        pneg;

	assign {side_c, ub_c, nb_c, zero1_c, den0_c, negq_c, ks_c} = sd_side[QW2];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			pmag[j] = (ks_c == 2'(j)) ? sd_q[QW2][0] : ONE_Q;
			pneg[j] = (ks_c == 2'(j)) && negq_c;
		end
	end

	logic              u2_vld;
	logic [2:0][F:0]   up;
	unit_flags_t       fl2;
	logic [SW2-1:0]    side2;

	gcv_unit #(.FRAC(F), .MW(QW2), .SW(SW2)) u_phat (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (sd_vld[QW2]),
		.mag_i   (pmag),
		.neg_i   (pneg),
		.side_i  ({side_c, ub_c, nb_c, zero1_c, den0_c}),
		.vld_o   (u2_vld),
		.u_o     (up),
		.flags_o (fl2),
		.side_o  (side2)
	);

	logic [W-1:0]    vpar_d, vperp_d;
	logic [2:0][F:0] ub_d;
	logic [2:0]      nb_d;
	logic            zero1_d, den0_d;
	logic [W-1:0]    mvpar, mvperp;
	fault_t          flt_c;

	assign {vpar_d, vperp_d, ub_d, nb_d, zero1_d, den0_d} = side2;
	assign mvpar  = vpar_d[W-1] ? (~vpar_d + 1'b1) : vpar_d;
	assign mvperp = vperp_d[W-1] ? (~vperp_d + 1'b1) : vperp_d;
	assign flt_c  = zero1_d ? FLT_ZERO_FIELD :
		((den0_d || fl2.zero) ? FLT_ZERO_DIV : FLT_OK);

	// scale: products
	logic            vld_s2;
	logic [W:0]      phpar_s2 [3];
	logic [W:0]      phper_s2 [3];
	logic [2*F:0]    plpar_s2 [3];
	logic [2*F:0]    plper_s2 [3];
	logic [2:0]      sgpar_s2, sgper_s2;
	fault_t          flt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= u2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				phpar_s2[j] <= mvpar[W-1:F] * ub_d[j];
				plpar_s2[j] <= mvpar[F-1:0] * ub_d[j];
				phper_s2[j] <= mvperp[W-1:F] * up[j];
				plper_s2[j] <= mvperp[F-1:0] * up[j];
				sgpar_s2[j] <= vpar_d[W-1] ^ nb_d[j];
				sgper_s2[j] <= vperp_d[W-1] ^ fl2.neg[j];
			end
			flt_s2 <= flt_c;
		end
	end

	// scale: terms
	logic                vld_s3;
	logic signed [W+2:0] tpar_s3 [3];
	logic signed [W+2:0] tper_s3 [3];
	fault_t              flt_s3;
	logic [W+1:0]        tpar_c [3];
	logic [W+1:0]        tper_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			tpar_c[j] = (W+2)'(phpar_s2[j]) + (W+2)'(plpar_s2[j] >> F);
			tper_c[j] = (W+2)'(phper_s2[j]) + (W+2)'(plper_s2[j] >> F);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				tpar_s3[j] <= sgpar_s2[j] ? -{1'b0, tpar_c[j]} : {1'b0, tpar_c[j]};
				tper_s3[j] <= sgper_s2[j] ? -{1'b0, tper_c[j]} : {1'b0, tper_c[j]};
			end
			flt_s3 <= flt_s2;
		end
	end

	// sum and saturate
	logic                vld_s4;
	logic [2:0][W-1:0]   vel_s4;
	fault_t              flt_s4;
	logic signed [W+3:0] sum_c [3];
	logic [2:0][W-1:0]   vel_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_c[j] = (W+4)'(tpar_s3[j]) + (W+4)'(tper_s3[j]);
			if (flt_s3 != FLT_OK)
				vel_c[j] = '0;
			else if (sum_c[j] > SAT_HI)
				vel_c[j] = SAT_HI[W-1:0];
			else if (sum_c[j] < SAT_LO)
				vel_c[j] = SAT_LO[W-1:0];
			else
				vel_c[j] = sum_c[j][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vel_s4 <= vel_c;
			flt_s4 <= flt_s3;
		end
	end

	// output word and skid entry
	logic              o_vld_q;
	logic [2:0][W-1:0] o_vel_q, sk_vel_q;
	fault_t            o_flt_q, sk_flt_q;
	logic              push, pop;

	assign push = en && vld_s4;
	assign pop  = o_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop)
				skid_vld_q <= 1'b0;
		end else if (push) begin
			if (o_vld_q && !pop)
				skid_vld_q <= 1'b1;
			else
				o_vld_q <= 1'b1;
		end else if (pop) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				o_vel_q <= sk_vel_q;
				o_flt_q <= sk_flt_q;
			end
		end else if (push) begin
			if (o_vld_q && !pop) begin
				sk_vel_q <= vel_s4;
				sk_flt_q <= flt_s4;
			end else begin
				o_vel_q <= vel_s4;
				o_flt_q <= flt_s4;
			end
		end
	end

	assign m_tvalid = o_vld_q;
	assign m_tdata  = OUT_W'(o_vel_q);
	assign m_tuser  = o_flt_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> o_vld_q)
		else $error("skid word held without an output word");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(o_vld_q && !m_tready))
		else $error("skid filled without a stalled output");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !m_tready |=> skid_vld_q)
		else $error("skid word lost while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != FLT_OK) |-> m_tdata == '0)
		else $error("faulted word carries non-zero velocity");

endmodule

FILE: sim/guiding_center_velocity_to_3d_tb.sv
// guiding_center_velocity_to_3d_tb: self-checking bench for the guiding-centre velocity
// converter. A directed table, then random words, are checked against a local predictor.
// Depends on gcv_pkg and guiding_center_velocity_to_3d.
`timescale 1ns / 1ps

module guiding_center_velocity_to_3d_tb
	import gcv_pkg::*;
();

	localparam int FB = 16;
	localparam int WB = 32;
	localparam int RANDOM_WORDS = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [WB-1:0] vx, vy, vz;
		fault_t        flt;
	} velocity_t;

	typedef struct {
		logic [WB-1:0] vpar, vperp, bx, by, bz;
		bit            typed;
		fault_t        flt;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [((5*WB+7)/8)*8-1:0]           s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [((3*WB+7)/8)*8-1:0]           m_tdata;
	logic [1:0]                          m_tuser;

	velocity_t expected_vel[$];
	int        mismatches;
	int        cycles;
	int        send_idle_pct;
	int        recv_idle_pct;
	stim_row_t rows[14];

	guiding_center_velocity_to_3d #(.FRAC_BITS(FB), .WORD_BITS(WB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint signd(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// shrink the vector in place, return floor of its length
	function automatic longint unsigned shrunk_length(ref longint v[3]);
		longint unsigned m[3], top, sum;
		m[0] = magn(v[0]); m[1] = magn(v[1]); m[2] = magn(v[2]);
		top = m[0];
		if (m[1] > top) top = m[1];
		if (m[2] > top) top = m[2];
		while (top > 64'h8000_0000) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = signd(m[i], v[i] < 0);
			sum += m[i] * m[i];
		end
		return root_floor(sum);
	endfunction

	function automatic void make_unit(ref longint v[3], input longint unsigned len);
		for (int i = 0; i < 3; i++)
			v[i] = signd((magn(v[i]) << FB) / len, v[i] < 0);
	endfunction

	function automatic longint scaled(longint v, longint c);
		longint unsigned mv, mc, t;
		mv = magn(v);
		mc = magn(c);
		t = (mv >> FB) * mc + (((mv & ((64'd1 << FB) - 1)) * mc) >> FB);
		return signd(t, (v < 0) != (c < 0));
	endfunction

	function automatic logic [WB-1:0] clamp(longint x);
		if (x > 64'sd2147483647) return 32'h7fff_ffff;
		if (x < -64'sd2147483648) return 32'h8000_0000;
		return x[WB-1:0];
	endfunction

	function automatic velocity_t predict_velocity(logic [WB-1:0] vpar, vperp, bx, by, bz);
		velocity_t     r;
		longint        bh[3], ph[3], num, den, sp, se;
		longint unsigned len, q;
		int            k;
		r = '{vx: '0, vy: '0, vz: '0, flt: FLT_OK};
		sp = longint'(signed'(vpar));
		se = longint'(signed'(vperp));
		bh[0] = longint'(signed'(bx));
		bh[1] = longint'(signed'(by));
		bh[2] = longint'(signed'(bz));
		len = shrunk_length(bh);
		if (len == 0) begin
			r.flt = FLT_ZERO_FIELD;
			return r;
		end
		make_unit(bh, len);
		if (bh[2] > bh[1] && bh[2] > bh[0]) begin
			k = 2; num = bh[0] + bh[1];
		end else if (bh[1] > bh[0]) begin
			k = 1; num = bh[2] + bh[0];
		end else begin
			k = 0; num = bh[1] + bh[2];
		end
		den = bh[k];
		if (den == 0) begin
			r.flt = FLT_ZERO_DIV;
			return r;
		end
		for (int i = 0; i < 3; i++) ph[i] = longint'(1) << FB;
		q = (magn(num) << FB) / magn(den);
		ph[k] = signd(q, num != 0 && ((num < 0) == (den < 0)));
		len = shrunk_length(ph);
		if (len == 0) begin
			r.flt = FLT_ZERO_DIV;
			return r;
		end
		make_unit(ph, len);
		r.vx = clamp(scaled(sp, bh[0]) + scaled(se, ph[0]));
		r.vy = clamp(scaled(sp, bh[1]) + scaled(se, ph[1]));
		r.vz = clamp(scaled(sp, bh[2]) + scaled(se, ph[2]));
		return r;
	endfunction

	function automatic logic [WB-1:0] random_component();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return '0;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2, 3: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
				: -$urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(logic [WB-1:0] vpar, vperp, bx, by, bz,
			bit typed, velocity_t typed_vel);
		velocity_t e;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {bz, by, bx, vperp, vpar};
		do @(posedge clk); while (!s_tready);
		e = typed ? typed_vel : predict_velocity(vpar, vperp, bx, by, bz);
		expected_vel.push_back(e);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_vel.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		velocity_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_vel.size() == 0) begin
				if (mismatches < 10) $display("unexpected word: %h tuser %0d", m_tdata, m_tuser);
				mismatches++;
			end else begin
				e = expected_vel.pop_front();
				if (m_tdata[WB-1:0] !== e.vx || m_tdata[2*WB-1:WB] !== e.vy
						|| m_tdata[3*WB-1:2*WB] !== e.vz || m_tuser !== e.flt) begin
					if (mismatches < 10)
						$display("mismatch: exp %h %h %h f%0d got %h %h %h f%0d",
							e.vx, e.vy, e.vz, e.flt, m_tdata[WB-1:0],
							m_tdata[2*WB-1:WB], m_tdata[3*WB-1:2*WB], m_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		velocity_t fz, fd, none;
		fz = '{vx: '0, vy: '0, vz: '0, flt: FLT_ZERO_FIELD};
		fd = '{vx: '0, vy: '0, vz: '0, flt: FLT_ZERO_DIV};
		none = fz;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 37;
		recv_idle_pct = 77;
		arst_n = 1'b0;
		// typed rows: zero field, and largest bhat component zero (all others negative)
		rows[0]  = '{32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1, FLT_ZERO_FIELD};
		rows[1]  = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 1, FLT_ZERO_FIELD};
		rows[2]  = '{32'h0001_0000, 32'h0002_0000, 0, 32'hffff_0000, 32'hffff_0000, 1,
			FLT_ZERO_DIV};
		rows[3]  = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, FLT_OK};
		rows[4]  = '{32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, FLT_OK};
		rows[5]  = '{32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, FLT_OK};
		rows[6]  = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 0, FLT_OK};
		rows[7]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0, FLT_OK};
		rows[8]  = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 0, FLT_OK};
		rows[9]  = '{32'h0003_8000, 32'hfffc_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000,
			0, FLT_OK};
		rows[10] = '{32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000,
			32'h0001_0000, 0, FLT_OK};
		rows[11] = '{0, 0, 1, 0, 0, 0, FLT_OK};
		rows[12] = '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 0, FLT_OK};
		rows[13] = '{32'h1234_5678, 32'h8765_4321, 32'hffff_0000, 32'h0000_8000,
			32'h7fff_0000, 0, FLT_OK};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) begin
			none.flt = rows[i].flt;
			send_word(rows[i].vpar, rows[i].vperp, rows[i].bx, rows[i].by, rows[i].bz,
				rows[i].typed, rows[i].flt == FLT_ZERO_FIELD ? fz : fd);
		end
		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			send_idle_pct = phase == 0 ? 37 : (phase == 1 ? 77 : 0);
			recv_idle_pct = phase == 0 ? 77 : (phase == 1 ? 37 : 0);
			for (int n = 0; n < RANDOM_WORDS / 3; n++)
				send_word($urandom, $urandom, random_component(), random_component(),
					random_component(), 0, none);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_vel.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
sv/gcv_pkg.sv
sv/gcv_sqrt_cell.sv
sv/gcv_div_cell.sv
sv/gcv_unit.sv
sv/guiding_center_velocity_to_3d.sv
sim/guiding_center_velocity_to_3d_tb.sv
